// ===== hw/rtl/ddpu_pkg.sv =====
// Package with the sequencer states and fixed constants of the pose update core.
package ddpu_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT_L,
        ST_ROT_R,
        ST_ARC_L,
        ST_ARC_R,
        ST_MOD,
        ST_REDUCE,
        ST_CORDIC,
        ST_POS_X,
        ST_POS_Y,
        ST_DIV_INIT,
        ST_DIV,
        ST_HEAD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        REG_WHEEL_RADIUS = 2'd0,
        REG_AXIS_LENGTH  = 2'd1,
        REG_TIME_STEP    = 2'd2
    } t_reg_index;

    localparam logic signed [35:0] Q30_TWO_PI = 36'sd6746518852;
    localparam logic signed [35:0] Q30_GAIN   = 36'sd652032874;
    localparam int                 TABLE_LEN  = 24;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048576;
            5'd11: v = 36'sd524288;
            5'd12: v = 36'sd262144;
            5'd13: v = 36'sd131072;
            5'd14: v = 36'sd65536;
            5'd15: v = 36'sd32768;
            5'd16: v = 36'sd16384;
            5'd17: v = 36'sd8192;
            5'd18: v = 36'sd4096;
            5'd19: v = 36'sd2048;
            5'd20: v = 36'sd1024;
            5'd21: v = 36'sd512;
            5'd22: v = 36'sd256;
            5'd23: v = 36'sd128;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ddpu_mul.sv =====
// Shared signed 33 by 33 bit multiplier with a registered product.
module ddpu_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/differential_drive_pose_update_core.sv =====
// Top level of the differential-drive pose update core.
// Usage: the input channel carries one word per tick with the left and right
// wheel speeds; the output channel returns one word with the new x, y,
// heading and both accumulated wheel angles, all signed fixed point.
// The user must write wheel radius, axis length and time step through the
// configuration port only while the core is idle; the core does not enforce
// this. Writes take effect at once. Each word passes a small sequencer that
// drives one shared multiplier, one CORDIC adder stage, a compare-and-subtract
// reduction of the heading and a restoring divider. In order it forms four
// products for the wheel rotations and arcs, reduces the heading, runs the
// CORDIC steps (CORDIC_STEPS, capped at 24), forms two products for the
// position and takes the quotient bits of the heading change.
// The core accepts no new word until the result has been taken; while the
// receiver stalls the result is held unchanged on the output.
// Reset clears the pose and wheel angles to zero and loads the default
// register values; the core is ready as soon as reset is released.
module differential_drive_pose_update_core #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_left_wheel_speed,
    input  logic signed [31:0] i_right_wheel_speed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_position_x,
    output logic signed [31:0] o_position_y,
    output logic signed [31:0] o_heading,
    output logic signed [31:0] o_left_wheel_angle,
    output logic signed [31:0] o_right_wheel_angle,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    import ddpu_pkg::*;

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0] HALF = 36'sd1 <<< (SH - 1);
    localparam logic signed [35:0] TWO_PI = (Q30_TWO_PI + HALF) >>> SH;
    localparam logic signed [35:0] PI_C = ((Q30_TWO_PI / 2) + HALF) >>> SH;
    localparam logic signed [35:0] HPI_C = ((Q30_TWO_PI / 4) + HALF) >>> SH;
    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int DBITS = 32 + FRAC_BITS + 1;
    localparam int MOD_TOP = 29 - FRAC_BITS;

    t_state r_state, n_state;
    logic [19:0] r_radius, r_axis;
    logic [15:0] r_tstep;
    logic signed [31:0] r_px, r_py, r_hd, r_lacc, r_racc;
    logic signed [31:0] r_lspd, r_rspd, r_lrot, r_rrot, r_larc, r_rarc;
    logic signed [35:0] r_cx, r_cy, r_ang;
    logic r_neg, r_phase, r_valid;
    logic [5:0] r_cnt;
    logic [DBITS-1:0] r_quo, r_rem;
    logic r_dneg;

    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p, m_sh;

    ddpu_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_sh));
    assign m_p = m_sh >>> FRAC_BITS;

    logic signed [35:0] cos_q, sin_q, cx_r, cy_r, atan_f, red;
    logic signed [35:0] hd_abs, mod_sub;
    logic signed [32:0] travel;
    logic signed [33:0] diff;
    logic [DBITS-1:0] diff_abs;
    logic [DBITS:0] trial;
    logic signed [DBITS:0] turn_full;
    logic signed [33:0] hd_new;

    always_comb begin
        cx_r = (r_cx + HALF) >>> SH;
        cy_r = (r_cy + HALF) >>> SH;
        cos_q = r_neg ? -cx_r : cx_r;
        sin_q = r_neg ? -cy_r : cy_r;
        atan_f = (atan_q30(r_cnt[4:0]) + HALF) >>> SH;
        travel = ($signed({r_larc[31], r_larc}) + $signed({r_rarc[31], r_rarc})) >>> 1;
        diff = $signed({{2{r_rarc[31]}}, r_rarc}) - $signed({{2{r_larc[31]}}, r_larc});
        diff_abs = DBITS'(diff[33] ? -diff : diff) << FRAC_BITS;
        trial = {r_rem, r_quo[DBITS-1]} - {{(DBITS-19){1'b0}}, (r_axis == 20'd0) ? 20'd1 : r_axis};
        turn_full = r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        hd_abs = r_hd[31] ? -36'(r_hd) : 36'(r_hd);
        mod_sub = TWO_PI <<< r_cnt;
        red = (r_hd[31] && (r_ang != 36'sd0)) ? TWO_PI - r_ang : r_ang;
        if (red > PI_C) red = red - TWO_PI;
        hd_new = 34'(r_hd) + 34'(sat32(66'(turn_full)));
        if (hd_new > 34'(TWO_PI)) hd_new = hd_new - 34'(TWO_PI);
        if (hd_new < -34'(TWO_PI)) hd_new = hd_new + 34'(TWO_PI);
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_ROT_L: begin m_a = 33'(r_lspd); m_b = $signed({17'd0, r_tstep}); end
            ST_ROT_R: begin m_a = 33'(r_rspd); m_b = $signed({17'd0, r_tstep}); end
            ST_ARC_L: begin m_a = 33'(r_lrot); m_b = $signed({13'd0, r_radius}); end
            ST_ARC_R: begin m_a = 33'(r_rrot); m_b = $signed({13'd0, r_radius}); end
            ST_POS_X: begin m_a = cos_q[32:0]; m_b = travel; end
            ST_POS_Y: begin m_a = sin_q[32:0]; m_b = travel; end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_valid) n_state = ST_ROT_L;
            ST_ROT_L:    if (r_phase) n_state = ST_ROT_R;
            ST_ROT_R:    if (r_phase) n_state = ST_ARC_L;
            ST_ARC_L:    if (r_phase) n_state = ST_ARC_R;
            ST_ARC_R:    if (r_phase) n_state = ST_MOD;
            ST_MOD:      if (r_cnt == 6'd0) n_state = ST_REDUCE;
            ST_REDUCE:   n_state = ST_CORDIC;
            ST_CORDIC:   if (r_cnt == 6'(NSTEP - 1)) n_state = ST_POS_X;
            ST_POS_X:    if (r_phase) n_state = ST_POS_Y;
            ST_POS_Y:    if (r_phase) n_state = ST_DIV_INIT;
            ST_DIV_INIT: n_state = ST_DIV;
            ST_DIV:      if (r_cnt == 6'(DBITS - 1)) n_state = ST_HEAD;
            ST_HEAD:     n_state = ST_OUT;
            ST_OUT:      if (i_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_radius <= 20'd6554;
            r_axis   <= 20'd13107;
            r_tstep  <= 16'd655;
            r_px <= '0; r_py <= '0; r_hd <= '0; r_lacc <= '0; r_racc <= '0;
            r_phase <= 1'b0;
            r_valid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WHEEL_RADIUS: r_radius <= i_cfg_data;
                    REG_AXIS_LENGTH:  r_axis <= i_cfg_data;
                    REG_TIME_STEP:    r_tstep <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            r_phase <= (n_state == r_state) ? ~r_phase : 1'b0;
            case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_lspd <= i_left_wheel_speed;
                    r_rspd <= i_right_wheel_speed;
                end
                ST_ROT_L: if (r_phase) r_lrot <= sat32(m_p);
                ST_ROT_R: if (r_phase) begin
                    r_rrot <= sat32(m_p);
                    r_lacc <= r_lacc + r_lrot;
                    r_racc <= r_racc + sat32(m_p);
                end
                ST_ARC_L: if (r_phase) r_larc <= sat32(m_p);
                ST_ARC_R: if (r_phase) begin
                    r_rarc <= sat32(m_p);
                    r_ang <= hd_abs;
                    r_cnt <= 6'(MOD_TOP);
                end
                ST_MOD: begin
                    if (r_ang >= mod_sub) r_ang <= r_ang - mod_sub;
                    r_cnt <= r_cnt - 6'd1;
                end
                ST_REDUCE: begin
                    if (red > HPI_C) begin
                        r_ang <= red - PI_C; r_neg <= 1'b1;
                    end else if (red < -HPI_C) begin
                        r_ang <= red + PI_C; r_neg <= 1'b1;
                    end else begin
                        r_ang <= red; r_neg <= 1'b0;
                    end
                    r_cx <= Q30_GAIN;
                    r_cy <= '0;
                    r_cnt <= '0;
                end
                ST_CORDIC: begin
                    if (r_ang >= 0) begin
                        r_cx <= r_cx - (r_cy >>> r_cnt);
                        r_cy <= r_cy + (r_cx >>> r_cnt);
                        r_ang <= r_ang - atan_f;
                    end else begin
                        r_cx <= r_cx + (r_cy >>> r_cnt);
                        r_cy <= r_cy - (r_cx >>> r_cnt);
                        r_ang <= r_ang + atan_f;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_POS_X: if (r_phase)
                    r_px <= sat32(66'(r_px) + m_p);
                ST_POS_Y: if (r_phase)
                    r_py <= sat32(66'(r_py) + m_p);
                ST_DIV_INIT: begin
                    r_quo <= diff_abs;
                    r_rem <= '0;
                    r_dneg <= diff[33];
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    if (!trial[DBITS]) begin
                        r_rem <= trial[DBITS-1:0];
                        r_quo <= {r_quo[DBITS-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DBITS-2:0], r_quo[DBITS-1]};
                        r_quo <= {r_quo[DBITS-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_HEAD: begin
                    r_hd <= sat32(66'(hd_new));
                    r_valid <= 1'b1;
                end
                ST_OUT: if (i_ready) r_valid <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_position_x = r_px;
    assign o_position_y = r_py;
    assign o_heading = r_hd;
    assign o_left_wheel_angle = r_lacc;
    assign o_right_wheel_angle = r_racc;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepted a word while a result waits");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_heading)))
        else $error("result changed under stall");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_ROT_L)) else $error("start lost");
`endif
endmodule
